FILE: design/rdsc_pkg.sv
// shared types, constants and helpers for the radix digit string converter
package rdsc_pkg;

    localparam int DIGIT_W        = 4;   // one alphabet index
    localparam int RADIX_W        = 5;   // base_length register width
    localparam int GROUP_CELLS    = 8;   // digit cells per carry group
    localparam int ALPHABET_SLOTS = 16;
    localparam int SYM_W          = 8;
    localparam int CFG_ADDR_W     = 2;
    localparam int CFG_DATA_W     = 64;

    localparam logic [CFG_ADDR_W-1:0] CFG_BASE_LENGTH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SYMBOLS_LOW  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SYMBOLS_HIGH = 2'd2;

    localparam logic [SYM_W-1:0]   CHAR_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0]   CHAR_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0]   CHAR_ZERO  = 8'h30;
    localparam logic [SYM_W-1:0]   CHAR_NUL   = 8'h00;
    localparam logic [RADIX_W-1:0] MIN_RADIX  = 5'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_DRAIN,
        ST_EMIT,
        ST_ONE
    } t_state;

    // control from the sequencer to the digit cell row
    typedef struct packed {
        logic clear;
        logic step;
        logic bit_in;
        logic shift;
    } t_row_ctl;

    // alphabet symbol at index idx, symbol 0 in the lowest byte
    function automatic logic [SYM_W-1:0] sym_at(
        input logic [ALPHABET_SLOTS*SYM_W-1:0] syms,
        input logic [DIGIT_W-1:0]              idx
    );
        sym_at = syms[idx*SYM_W +: SYM_W];
    endfunction

endpackage

FILE: design/rdsc_alpha_check.sv
// alphabet validity check: length range, forbidden symbols, repeated symbols
module rdsc_alpha_check
    import rdsc_pkg::*;
#(
    parameter int MAX_RADIX = 16
) (
    input  logic [RADIX_W-1:0]              i_base_length,
    input  logic [ALPHABET_SLOTS*SYM_W-1:0] i_symbols,
    output logic                            o_ok
);

    localparam logic [6:0] MaxRadixW = 7'(MAX_RADIX);

    logic [ALPHABET_SLOTS-1:0] active;
    logic                      len_bad;
    logic                      sym_bad;
    logic                      dup_bad;

    always_comb begin
        for (int i = 0; i < ALPHABET_SLOTS; i++) begin
            active[i] = (RADIX_W'(i) < i_base_length);
        end
    end

    assign len_bad = (i_base_length < MIN_RADIX)
                  || (i_base_length > RADIX_W'(ALPHABET_SLOTS))
                  || ({2'b00, i_base_length} > MaxRadixW);

    always_comb begin
        logic [SYM_W-1:0] c;
        sym_bad = 1'b0;
        for (int i = 0; i < ALPHABET_SLOTS; i++) begin
            c = i_symbols[i*SYM_W +: SYM_W];
            if (active[i] && (c == CHAR_PLUS || c == CHAR_MINUS || c == CHAR_NUL)) begin
                sym_bad = 1'b1;
            end
        end
    end

    // active slots form a prefix, so j active implies i active
    always_comb begin
        dup_bad = 1'b0;
        for (int i = 0; i < ALPHABET_SLOTS; i++) begin
            for (int j = i + 1; j < ALPHABET_SLOTS; j++) begin
                if (active[j]
                    && i_symbols[i*SYM_W +: SYM_W] == i_symbols[j*SYM_W +: SYM_W]) begin
                    dup_bad = 1'b1;
                end
            end
        end
    end

    assign o_ok = !(len_bad || sym_bad || dup_bad);

endmodule

FILE: design/rdsc_digit_row.sv
// row of radix digit cells: bit-serial doubling conversion and top-first readout
module rdsc_digit_row
    import rdsc_pkg::*;
#(
    parameter int NUM_GROUPS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_row_ctl           i_ctl,
    input  logic [RADIX_W-1:0] i_radix,
    output logic [DIGIT_W-1:0] o_top,
    output logic               o_busy
);

    localparam int NumCells = NUM_GROUPS * GROUP_CELLS;

    logic [DIGIT_W-1:0]    r_dig [NumCells];
    logic [DIGIT_W-1:0]    n_dig [NumCells];
    logic [NUM_GROUPS-1:0] r_en;
    logic                  r_carry [NUM_GROUPS];
    logic                  n_cout [NUM_GROUPS];

    // each cell: d = 2d + carry, reduced by the radix; each group steps in the cycle
    // after the group below it, so the carry chain spans at most one group
    always_comb begin
        logic         c;
        logic [DIGIT_W:0] t;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            c = r_carry[g];
            for (int k = 0; k < GROUP_CELLS; k++) begin
                t = {r_dig[g*GROUP_CELLS + k], c};
                if (t >= i_radix) begin
                    n_dig[g*GROUP_CELLS + k] = DIGIT_W'(t - i_radix);
                    c = 1'b1;
                end else begin
                    n_dig[g*GROUP_CELLS + k] = DIGIT_W'(t);
                    c = 1'b0;
                end
                if (!r_en[g]) begin
                    n_dig[g*GROUP_CELLS + k] = r_dig[g*GROUP_CELLS + k];
                end
            end
            n_cout[g] = c;
        end
        // readout moves every cell one place toward the top
        if (i_ctl.shift) begin
            n_dig[0] = '0;
            for (int i = 1; i < NumCells; i++) begin
                n_dig[i] = r_dig[i-1];
            end
        end
        if (i_ctl.clear) begin
            for (int i = 0; i < NumCells; i++) begin
                n_dig[i] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NumCells; i++) begin
            r_dig[i] <= n_dig[i];
        end
        r_carry[0] <= i_ctl.bit_in;
        for (int g = 1; g < NUM_GROUPS; g++) begin
            r_carry[g] <= n_cout[g-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= '0;
        end else begin
            r_en <= NUM_GROUPS'({r_en, i_ctl.step});
        end
    end

    assign o_top  = r_dig[NumCells-1];
    assign o_busy = |r_en;

endmodule

FILE: design/radix_digit_string_converter.sv
// Radix digit string converter top level. Each 64-bit number on the input stream
// becomes its digits, most significant first, one symbol byte per output word,
// drawn from a configured alphabet whose length is the radix. A zero number gives
// the single character '0'; an invalid alphabet gives one word with tuser set.
// A nonzero number is converted bit-serially: its bits enter the digit cell row
// one per cycle, with a register of carry skew between groups of eight cells;
// the cells are then read out one cell per cycle, leading zeros dropped, and a
// digit waits while the output register is full. Zero and error results skip
// the conversion.
// The final word may wait in the output register while the next number converts.
module radix_digit_string_converter
    import rdsc_pkg::*;
#(
    parameter int MAX_RADIX  = 16,
    parameter int VALUE_BITS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // input stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [63:0]           i_s_tdata,   // number[63:0]
    // output stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [SYM_W-1:0]      o_m_tdata,   // symbol[7:0]
    output logic                  o_m_tlast,
    output logic                  o_m_tuser    // bad_alphabet
);

    localparam int NumGroups = (VALUE_BITS + GROUP_CELLS - 1) / GROUP_CELLS;
    localparam int NumCells  = NumGroups * GROUP_CELLS;
    localparam int LeftW     = $clog2(NumCells);
    localparam int CntW      = $clog2(VALUE_BITS);

    t_state r_state, n_state;

    logic [RADIX_W-1:0]    r_base_length;
    logic [63:0]           r_symbols_low;
    logic [63:0]           r_symbols_high;

    logic [VALUE_BITS-1:0] r_value;
    logic [CntW-1:0]       r_cnt;
    logic [LeftW-1:0]      r_left;
    logic                  r_seen;
    logic                  r_one_bad;

    logic                  r_m_tvalid;
    logic [SYM_W-1:0]      r_m_tdata;
    logic                  r_m_tlast;
    logic                  r_m_tuser;

    logic                  alpha_ok;
    logic                  s_acc;
    logic                  out_free;
    logic                  num_zero;
    logic                  skip;
    logic                  load;
    t_row_ctl              row_ctl;
    logic [DIGIT_W-1:0]    top_digit;
    logic                  row_busy;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_length  <= '0;
            r_symbols_low  <= '0;
            r_symbols_high <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_BASE_LENGTH:  r_base_length  <= i_cfg_wdata[RADIX_W-1:0];
                CFG_SYMBOLS_LOW:  r_symbols_low  <= i_cfg_wdata;
                CFG_SYMBOLS_HIGH: r_symbols_high <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    rdsc_alpha_check #(
        .MAX_RADIX (MAX_RADIX)
    ) u_alpha (
        .i_base_length (r_base_length),
        .i_symbols     ({r_symbols_high, r_symbols_low}),
        .o_ok          (alpha_ok)
    );

    rdsc_digit_row #(
        .NUM_GROUPS (NumGroups)
    ) u_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (row_ctl),
        .i_radix (r_base_length),
        .o_top   (top_digit),
        .o_busy  (row_busy)
    );

    assign s_acc    = i_s_tvalid && o_s_tready;
    assign out_free = !r_m_tvalid || i_m_tready;
    assign num_zero = (i_s_tdata[VALUE_BITS-1:0] == '0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    n_state = (!alpha_ok || num_zero) ? ST_ONE : ST_CONV;
                end
            end
            ST_CONV: begin
                if (r_cnt == '0) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!row_busy) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (load && r_left == '0) begin
                    n_state = ST_IDLE;
                end
            end
            ST_ONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_s_tready     = (r_state == ST_IDLE);
        // leading zeros of the cell row are dropped without a word
        skip           = (r_state == ST_EMIT) && !r_seen && top_digit == '0 && r_left != '0;
        load           = (r_state == ST_EMIT) && !skip && out_free;
        row_ctl.clear  = s_acc;
        row_ctl.step   = (r_state == ST_CONV);
        row_ctl.bit_in = r_value[VALUE_BITS-1];
        row_ctl.shift  = skip || load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (s_acc) begin
            r_seen <= 1'b0;
        end else if (load) begin
            r_seen <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_value   <= i_s_tdata[VALUE_BITS-1:0];
            r_cnt     <= CntW'(VALUE_BITS - 1);
            r_left    <= LeftW'(NumCells - 1);
            r_one_bad <= !alpha_ok;
        end else begin
            if (r_state == ST_CONV) begin
                r_value <= {r_value[VALUE_BITS-2:0], 1'b0};
                r_cnt   <= r_cnt - 1'b1;
            end
            if (skip || load) begin
                r_left <= r_left - 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (load || (r_state == ST_ONE && out_free)) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_m_tdata <= sym_at({r_symbols_high, r_symbols_low}, top_digit);
            r_m_tlast <= (r_left == '0);
            r_m_tuser <= 1'b0;
        end else if (r_state == ST_ONE && out_free) begin
            r_m_tdata <= r_one_bad ? CHAR_NUL : CHAR_ZERO;
            r_m_tlast <= 1'b1;
            r_m_tuser <= r_one_bad;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tlast  = r_m_tlast;
    assign o_m_tuser  = r_m_tuser;

endmodule

FILE: design/rdsc_checker.sv
// port-level checks for the radix digit string converter, bound to the top level
module rdsc_checker
    import rdsc_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_tvalid,
    input logic             o_s_tready,
    input logic             o_m_tvalid,
    input logic             i_m_tready,
    input logic [SYM_W-1:0] o_m_tdata,
    input logic             o_m_tlast,
    input logic             o_m_tuser
);

    // an error word is alone: last set and symbol cleared
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tlast && o_m_tdata == CHAR_NUL)
        else $error("error word without last or with nonzero symbol");

    // a digit word that is not the last never carries the error flag
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> !o_m_tuser)
        else $error("error flag on a non-final digit word");

    // one number at a time: no input word right after an accepted one
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input accepted on two consecutive cycles");

    // a stalled output word holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tlast) && $stable(o_m_tuser))
        else $error("output word changed while stalled");

endmodule

bind radix_digit_string_converter rdsc_checker u_rdsc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);

FILE: verif/radix_digit_string_converter_tb.sv
// self-checking testbench for the radix digit string converter: directed and random numbers
module radix_digit_string_converter_tb;
    import rdsc_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 2'd3;  // no register behind this index
    localparam int QUIET_LIMIT   = 3000;  // cycles with no word moving on either side
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 150;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 25;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
        logic             bad;
    } t_digit_word;

    typedef enum {
        FLAW_SHORT,
        FLAW_LONG,
        FLAW_PLUS,
        FLAW_MINUS,
        FLAW_NUL,
        FLAW_REPEAT
    } t_flaw;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [63:0]           i_s_tdata   = '0;   // number[63:0]
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [SYM_W-1:0]      o_m_tdata;          // symbol[7:0]
    logic                  o_m_tlast;
    logic                  o_m_tuser;          // bad_alphabet

    // shadow copy of the configuration registers
    logic [RADIX_W-1:0] radix_q      = '0;
    logic [63:0]        sym_low_q    = '0;
    logic [63:0]        sym_high_q   = '0;

    logic [63:0] pending_numbers[$];
    t_digit_word expected_words[$];
    t_digit_word next_word;

    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int burst_left     = 1;
    int gap_left       = 0;
    logic [15:0] stall_pattern = 16'hFFFF;
    logic [3:0]  stall_phase   = '0;
    int          stall_age     = 0;

    radix_digit_string_converter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [SYM_W-1:0] alphabet_at(input logic [DIGIT_W-1:0] idx);
        logic [127:0] all_syms;
        all_syms = {sym_high_q, sym_low_q};
        return all_syms[idx*SYM_W +: SYM_W];
    endfunction

    function automatic bit alphabet_ok();
        logic [SYM_W-1:0] c;
        if (radix_q < MIN_RADIX || radix_q > ALPHABET_SLOTS) return 1'b0;
        for (int i = 0; i < radix_q; i++) begin
            c = alphabet_at(DIGIT_W'(i));
            if (c == CHAR_PLUS || c == CHAR_MINUS || c == CHAR_NUL) return 1'b0;
            for (int j = i + 1; j < radix_q; j++)
                if (alphabet_at(DIGIT_W'(j)) == c) return 1'b0;
        end
        return 1'b1;
    endfunction

    // expected symbols of one number, most significant digit first
    function automatic void predict_digits(input logic [63:0] number);
        logic [DIGIT_W-1:0] digits[64];
        logic [63:0]        rest;
        logic [63:0]        radix;
        int                 count;
        if (!alphabet_ok()) begin
            expected_words.push_back('{symbol: CHAR_NUL, last: 1'b1, bad: 1'b1});
            return;
        end
        if (number == '0) begin
            expected_words.push_back('{symbol: CHAR_ZERO, last: 1'b1, bad: 1'b0});
            return;
        end
        radix = 64'(radix_q);
        rest  = number;
        count = 0;
        while (rest != '0 && count < 64) begin
            digits[count] = DIGIT_W'(rest % radix);
            rest = rest / radix;
            count++;
        end
        for (int k = count - 1; k >= 0; k--)
            expected_words.push_back('{symbol: alphabet_at(digits[k]), last: (k == 0), bad: 1'b0});
    endfunction

    function automatic logic [127:0] pack_alphabet(input string s);
        logic [127:0] syms;
        syms = '0;
        for (int i = 0; i < s.len() && i < ALPHABET_SLOTS; i++) syms[i*SYM_W +: SYM_W] = s[i];
        return syms;
    endfunction

    function automatic logic [63:0] random_number();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3, 4: return v >> $urandom_range(1, 63);
            default: return v;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 50) $display("radix_digit_string_converter_tb: %0t %s", $time, msg);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        case (addr)
            CFG_BASE_LENGTH:  radix_q    = data[RADIX_W-1:0];
            CFG_SYMBOLS_LOW:  sym_low_q  = data;
            CFG_SYMBOLS_HIGH: sym_high_q = data;
            default: ;
        endcase
    endtask

    task automatic load_alphabet(input logic [RADIX_W-1:0] n, input logic [127:0] syms);
        logic [CFG_DATA_W-1:0] len_word;
        len_word = {$urandom, $urandom};  // upper bits must be dropped
        len_word[RADIX_W-1:0] = n;
        write_reg(CFG_BASE_LENGTH, len_word);
        write_reg(CFG_SYMBOLS_LOW, syms[63:0]);
        write_reg(CFG_SYMBOLS_HIGH, syms[127:64]);
        write_reg(CFG_UNUSED, {$urandom, $urandom});
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic make_alphabet(input bit flawed, output logic [RADIX_W-1:0] n,
                                 output logic [127:0] syms);
        logic [SYM_W-1:0] c;
        bit               clash;
        int               spot;
        int               other;
        t_flaw            flaw;
        case ($urandom_range(0, 3))
            0: n = RADIX_W'(2);
            1: n = RADIX_W'(16);
            default: n = RADIX_W'($urandom_range(2, 16));
        endcase
        syms = '0;
        for (int i = 0; i < ALPHABET_SLOTS; i++) begin
            if (i < n) begin
                do begin
                    c = SYM_W'($urandom_range(1, 255));
                    clash = (c == CHAR_PLUS) || (c == CHAR_MINUS);
                    for (int j = 0; j < i; j++)
                        if (syms[j*SYM_W +: SYM_W] == c) clash = 1'b1;
                end while (clash);
                syms[i*SYM_W +: SYM_W] = c;
            end else begin
                // slots past the radix are don't-care, any byte allowed
                syms[i*SYM_W +: SYM_W] = SYM_W'($urandom);
            end
        end
        if (flawed) begin
            flaw = t_flaw'($urandom_range(0, 5));
            spot = $urandom_range(0, n - 1);
            case (flaw)
                FLAW_SHORT:  n = RADIX_W'($urandom_range(0, 1));
                FLAW_LONG:   n = RADIX_W'($urandom_range(17, 31));
                FLAW_PLUS:   syms[spot*SYM_W +: SYM_W] = CHAR_PLUS;
                FLAW_MINUS:  syms[spot*SYM_W +: SYM_W] = CHAR_MINUS;
                FLAW_NUL:    syms[spot*SYM_W +: SYM_W] = CHAR_NUL;
                FLAW_REPEAT: begin
                    other = $urandom_range(0, n - 1);
                    if (other == spot) other = (spot + 1) % n;
                    syms[other*SYM_W +: SYM_W] = syms[spot*SYM_W +: SYM_W];
                end
            endcase
        end
    endtask

    // block is idle once every queued number went in and every word came out
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_numbers.size() != 0 || i_s_tvalid || expected_words.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // input side: bursts of random length separated by random gaps
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) predict_digits(i_s_tdata);
            if (!i_s_tvalid || o_s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_s_tvalid <= 1'b0;
                end else if (pending_numbers.size() > 0) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= pending_numbers.pop_front();
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // output side: check each word, stall on a rotating pattern
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch($sformatf("word %h last %b bad %b with nothing expected",
                                              o_m_tdata, o_m_tlast, o_m_tuser));
                end else begin
                    next_word = expected_words.pop_front();
                    if (o_m_tdata !== next_word.symbol)
                        report_mismatch($sformatf("symbol %h, expected %h",
                                                  o_m_tdata, next_word.symbol));
                    if (o_m_tlast !== next_word.last)
                        report_mismatch($sformatf("last %b, expected %b",
                                                  o_m_tlast, next_word.last));
                    if (o_m_tuser !== next_word.bad)
                        report_mismatch($sformatf("bad_alphabet %b, expected %b",
                                                  o_m_tuser, next_word.bad));
                end
            end
            i_m_tready <= stall_pattern[stall_phase];
            stall_phase = stall_phase + 1'b1;
            stall_age++;
            if (stall_age == 128) begin
                stall_age = 0;
                stall_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF
                                                           : (16'($urandom) | 16'h0001);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("radix_digit_string_converter_tb: FAIL");
            $finish;
        end
    end

    initial begin
        logic [RADIX_W-1:0] n;
        logic [127:0]       syms;
        bit                 flawed;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // registers at reset value: empty alphabet is an error
        pending_numbers.push_back('0);
        pending_numbers.push_back('1);
        wait_idle();

        load_alphabet(RADIX_W'(10), pack_alphabet("0123456789"));
        pending_numbers.push_back('0);
        pending_numbers.push_back(64'd1);
        pending_numbers.push_back(64'd9);
        pending_numbers.push_back(64'd10);
        pending_numbers.push_back(64'd12345678901234567890);
        pending_numbers.push_back('1);
        wait_idle();

        // binary, longest digit string
        load_alphabet(RADIX_W'(2), pack_alphabet("01"));
        pending_numbers.push_back('1);
        pending_numbers.push_back(64'h8000_0000_0000_0000);
        pending_numbers.push_back(64'd1);
        pending_numbers.push_back('0);
        wait_idle();

        load_alphabet(RADIX_W'(16), pack_alphabet("0123456789ABCDEF"));
        pending_numbers.push_back('1);
        pending_numbers.push_back(64'hDEAD_BEEF_0123_4567);
        pending_numbers.push_back('0);
        wait_idle();

        // alphabet without '0': zero still gives the literal character
        load_alphabet(RADIX_W'(3), pack_alphabet("xyz"));
        pending_numbers.push_back('0);
        pending_numbers.push_back(64'd26);
        wait_idle();

        // a '+' past the radix does not matter
        load_alphabet(RADIX_W'(2), pack_alphabet("ab+"));
        pending_numbers.push_back(64'd5);
        wait_idle();

        // broken alphabets
        load_alphabet(RADIX_W'(1), pack_alphabet("01"));
        pending_numbers.push_back(64'd7);
        wait_idle();
        load_alphabet(RADIX_W'(17), pack_alphabet("0123456789ABCDEF"));
        pending_numbers.push_back(64'd7);
        wait_idle();
        load_alphabet(RADIX_W'(31), pack_alphabet("0123456789ABCDEF"));
        pending_numbers.push_back('0);
        wait_idle();
        load_alphabet(RADIX_W'(4), pack_alphabet("01+3"));
        pending_numbers.push_back(64'd7);
        wait_idle();
        load_alphabet(RADIX_W'(3), pack_alphabet("ab-"));
        pending_numbers.push_back(64'd7);
        wait_idle();
        load_alphabet(RADIX_W'(3), pack_alphabet("ab"));  // third symbol is a zero byte
        pending_numbers.push_back(64'd7);
        wait_idle();
        load_alphabet(RADIX_W'(16), pack_alphabet("0123456789ABCDEA"));
        pending_numbers.push_back(64'd7);
        wait_idle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            flawed = ($urandom_range(0, 5) == 0);
            make_alphabet(flawed, n, syms);
            load_alphabet(n, syms);
            for (int k = 0; k < PHASE_ITEMS; k++) pending_numbers.push_back(random_number());
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (expected_words.size() != 0)
            report_mismatch($sformatf("%0d words never arrived", expected_words.size()));
        if (mismatch_count == 0) begin
            $display("radix_digit_string_converter_tb: PASS");
        end else begin
            $display("radix_digit_string_converter_tb: FAIL");
        end
        $finish;
    end

endmodule
